[rtl/core/ddro_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddro_pkg: shared types and constants of the drive ramp odometry unit
// Configuration record, controller commands and status, the CORDIC constants
// and the arctangent table.
// ----------------------------------------------------------------------------
package ddro_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
    localparam logic [2:0] REG_ACCEL       = 3'd1;
    localparam logic [2:0] REG_TIME_STEP   = 3'd2;
    localparam logic [2:0] REG_WHEEL_RAD   = 3'd3;
    localparam logic [2:0] REG_AXLE_LEN    = 3'd4;

    localparam logic [21:0] RST_MAX_SPEED = 22'd411775;
    localparam logic [23:0] RST_ACCEL     = 24'd411775;
    localparam logic [15:0] RST_TIME_STEP = 16'd655;
    localparam logic [19:0] RST_WHEEL_RAD = 20'd13107;
    localparam logic [19:0] RST_AXLE_LEN  = 20'd26214;

    // 2^32 / (2*pi), and the CORDIC start value 1/gain in Q30.
    localparam logic signed [32:0] INV_TWO_PI_Q32  = 33'sd683565276;
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    typedef struct packed {
        logic [21:0] max_speed;
        logic [23:0] accel;
        logic [15:0] time_step;
        logic [19:0] wheel_radius;
        logic [19:0] axle_length;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_ACCEPT, OP_M_STEP, OP_RAMP, OP_M_VL, OP_ANG_L, OP_ANG_R, OP_V,
        OP_W_START, OP_W_LAT, OP_M_WDT, OP_M_TURN, OP_HEAD, OP_SC_LAT,
        OP_S_MV, OP_S_SD, OP_S_MX, OP_S_X, OP_S_Y,
        OP_A_START, OP_A_LAT, OP_A_MX, OP_A_X, OP_A_Y, OP_DONE
    } op_t;

    typedef struct packed {
        op_t  op;
        logic div_start;
        logic cor_start;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic cor_busy;
        logic arc;
        logic out_free;
    } sts_t;

    // Rotation angles atan(2^-i) in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

[rtl/core/ddro_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddro_div: radix-2 restoring divider
// Unsigned quotient of num by den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddro_div
    import ddro_pkg::*;
#(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic [NW-1:0]      quo
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg, den_reg;
    logic [NW-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   shifted, diff;

    assign shifted = {rem_reg, q_reg[NW-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            if (!diff[DW]) begin
                rem_reg <= diff[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[DW-1:0];
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

[rtl/core/ddro_cordic.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddro_cordic: iterative sine and cosine
// Rotation mode CORDIC in Q30, one step per cycle, with half-turn folding.
// ----------------------------------------------------------------------------
module ddro_cordic
    import ddro_pkg::*;
#(
    parameter int STEPS     = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [23:0]                 angle,
    output logic                             busy,
    output logic signed [FRAC_BITS+1:0]      sin_val,
    output logic signed [FRAC_BITS+1:0]      cos_val
);
    localparam int CW = $clog2(STEPS);

    logic signed [32:0] x_reg, y_reg, z_reg;
    logic signed [32:0] dx, dy, at, xf, yf;
    logic               flip_reg, busy_reg;
    logic [CW-1:0]      cnt_reg;
    logic [31:0]        p, pz;
    logic               flip_s;

    assign p      = {angle, 8'h00};
    assign flip_s = p[31] ^ p[30];
    assign pz     = flip_s ? p + 32'h8000_0000 : p;

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign at = {1'b0, atan_turn(5'(cnt_reg))};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= {pz[31], pz};
            flip_reg <= flip_s;
        end else if (busy_reg) begin
            if (!z_reg[32]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    // Folded angles are undone by negating before the final floor shift.
    assign xf = flip_reg ? -x_reg : x_reg;
    assign yf = flip_reg ? -y_reg : y_reg;
    assign cos_val = (FRAC_BITS + 2)'(xf >>> (30 - FRAC_BITS));
    assign sin_val = (FRAC_BITS + 2)'(yf >>> (30 - FRAC_BITS));
    assign busy    = busy_reg;
endmodule
`default_nettype wire

[rtl/core/ddro_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddro_datapath: ramp, odometry and pose arithmetic
// One shared registered multiplier, a divider and a CORDIC, driven by op codes.
// ----------------------------------------------------------------------------
module ddro_datapath
    import ddro_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    input  wire logic signed [22:0] s_target_left,
    input  wire logic signed [22:0] s_target_right,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_pos_x,
    output logic signed [31:0]      m_pos_y,
    output logic [15:0]             m_heading,
    output logic signed [22:0]      m_speed_left,
    output logic signed [22:0]      m_speed_right,
    output logic signed [31:0]      m_angle_left,
    output logic signed [31:0]      m_angle_right
);
    localparam int NW = 32 + FRAC_BITS;
    localparam int DW = 32;
    localparam int CV = FRAC_BITS + 2;
    localparam logic signed [31:0] THR = 32'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic signed [65:0] MAX32 = 66'sd2147483647;
    localparam logic signed [65:0] MIN32 = -66'sd2147483648;

    function automatic logic signed [22:0] clamp_spd(input logic signed [22:0] v,
                                                     input logic [21:0] maxs);
        logic signed [22:0] m;
        m = {1'b0, maxs};
        if (v > m) return m;
        if (v < -m) return -m;
        return v;
    endfunction

    function automatic logic signed [22:0] ramp_clamp(input logic signed [22:0] cur,
                                                      input logic signed [22:0] tgt,
                                                      input logic [23:0] step,
                                                      input logic [21:0] maxs);
        logic signed [25:0] c, t, s, r, m;
        c = 26'(cur);
        t = 26'(tgt);
        s = {2'b00, step};
        m = {4'b0000, maxs};
        r = c;
        if (t > c) begin
            r = c + s;
            if (r > t) r = t;
        end else if (t < c) begin
            r = c - s;
            if (r < t) r = t;
        end
        if (r > m) r = m;
        else if (r < -m) r = -m;
        return 23'(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > MAX32) return 32'sh7FFF_FFFF;
        if (v < MIN32) return 32'sh8000_0000;
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] sat_quot(input logic [NW-1:0] q,
                                                    input logic neg);
        if (neg) begin
            if (q >= {{(NW-32){1'b0}}, 32'h8000_0000}) return 32'sh8000_0000;
            return 32'(32'd0 - q[31:0]);
        end
        if (q > {{(NW-32){1'b0}}, 32'h7FFF_FFFF}) return 32'sh7FFF_FFFF;
        return 32'(q[31:0]);
    endfunction

    // Odometry state.
    logic [31:0]        x_reg, y_reg, lang_reg, rang_reg;
    logic [23:0]        hd_reg;
    logic signed [22:0] lspd_reg, rspd_reg;
    // Per-item working values.
    logic signed [22:0] tl_reg, tr_reg;
    logic signed [31:0] v_reg, w_reg, sd_reg, r_reg;
    logic [23:0]        h2_reg;
    logic               arc_reg, div_neg_reg;
    logic signed [CV-1:0] s1_reg, c1_reg;
    logic signed [65:0] prod_reg;
    // Result register.
    logic               m_valid_reg;
    logic [31:0]        ox_reg, oy_reg, ola_reg, ora_reg;
    logic [15:0]        ohd_reg;
    logic signed [22:0] osl_reg, osr_reg;

    logic signed [32:0] ma, mb;
    logic signed [65:0] mag_prod;
    logic [31:0]        abs_v, abs_w;
    logic [NW-1:0]      div_num, div_quo;
    logic [DW-1:0]      div_den;
    logic               div_busy, cor_busy, out_free;
    logic signed [CV-1:0] cor_sin, cor_cos;
    logic [23:0]        dturn;

    assign out_free = !m_valid_reg || m_ready;
    assign mag_prod = prod_reg[65] ? -prod_reg : prod_reg;
    assign abs_v    = v_reg[31] ? 32'(-v_reg) : 32'(v_reg);
    assign abs_w    = w_reg[31] ? 32'(-w_reg) : 32'(w_reg);
    assign dturn    = 24'(prod_reg >>> (FRAC_BITS + 8));

    always_comb begin
        if (cmd.op == OP_W_START) begin
            div_num = mag_prod[NW-1:0];
            div_den = {12'd0, cfg.axle_length};
        end else begin
            div_num = {abs_v, {FRAC_BITS{1'b0}}};
            div_den = abs_w;
        end
    end

    ddro_div #(.NW(NW), .DW(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    ddro_cordic #(.STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.cor_start),
        .angle   ((cmd.op == OP_W_START) ? hd_reg : h2_reg),
        .busy    (cor_busy),
        .sin_val (cor_sin),
        .cos_val (cor_cos)
    );

    // Multiplier operand selection.
    always_comb begin
        case (cmd.op)
            OP_M_STEP: begin
                ma = {9'd0, cfg.accel};
                mb = {17'd0, cfg.time_step};
            end
            OP_M_VL: begin
                ma = 33'(lspd_reg);
                mb = {17'd0, cfg.time_step};
            end
            OP_ANG_L: begin
                ma = 33'(rspd_reg);
                mb = {17'd0, cfg.time_step};
            end
            OP_ANG_R: begin
                ma = 33'(rspd_reg) + 33'(lspd_reg);
                mb = {13'd0, cfg.wheel_radius};
            end
            OP_V: begin
                ma = 33'(rspd_reg) - 33'(lspd_reg);
                mb = {13'd0, cfg.wheel_radius};
            end
            OP_M_WDT: begin
                ma = 33'(w_reg);
                mb = {17'd0, cfg.time_step};
            end
            OP_M_TURN: begin
                ma = 33'(signed'(prod_reg[47:16]));
                mb = INV_TWO_PI_Q32;
            end
            OP_S_MV: begin
                ma = 33'(v_reg);
                mb = {17'd0, cfg.time_step};
            end
            OP_S_MX: begin
                ma = 33'(sd_reg);
                mb = 33'(c1_reg);
            end
            OP_S_X: begin
                ma = 33'(sd_reg);
                mb = 33'(s1_reg);
            end
            OP_A_MX: begin
                ma = 33'(r_reg);
                mb = 33'(cor_sin) - 33'(s1_reg);
            end
            OP_A_X: begin
                ma = 33'(r_reg);
                mb = 33'(cor_cos) - 33'(c1_reg);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
    end

    // Odometry state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= '0;
            y_reg       <= '0;
            hd_reg      <= '0;
            lspd_reg    <= '0;
            rspd_reg    <= '0;
            lang_reg    <= '0;
            rang_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (cmd.op)
                OP_RAMP: begin
                    lspd_reg <= ramp_clamp(lspd_reg, tl_reg, prod_reg[39:16],
                                           cfg.max_speed);
                    rspd_reg <= ramp_clamp(rspd_reg, tr_reg, prod_reg[39:16],
                                           cfg.max_speed);
                end
                OP_ANG_L: lang_reg <= lang_reg + {{9{prod_reg[38]}}, prod_reg[38:16]};
                OP_ANG_R: rang_reg <= rang_reg + {{9{prod_reg[38]}}, prod_reg[38:16]};
                OP_S_X, OP_A_X: x_reg <= x_reg + 32'(prod_reg >>> FRAC_BITS);
                OP_S_Y: y_reg <= y_reg + 32'(prod_reg >>> FRAC_BITS);
                OP_A_Y: y_reg <= y_reg - 32'(prod_reg >>> FRAC_BITS);
                OP_DONE: begin
                    if (out_free) hd_reg <= h2_reg;
                end
                default: begin
                end
            endcase
            if (cmd.op == OP_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working values and the result register.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                tl_reg <= clamp_spd(s_target_left, cfg.max_speed);
                tr_reg <= clamp_spd(s_target_right, cfg.max_speed);
            end
            OP_V: v_reg <= sat32(prod_reg >>> (FRAC_BITS + 1));
            OP_W_START: div_neg_reg <= prod_reg[65];
            OP_W_LAT: begin
                w_reg <= (cfg.axle_length == '0) ? 32'sd0 : sat_quot(div_quo, div_neg_reg);
            end
            OP_HEAD: begin
                h2_reg  <= hd_reg + dturn;
                arc_reg <= !((w_reg > -THR) && (w_reg < THR));
            end
            OP_SC_LAT: begin
                s1_reg <= cor_sin;
                c1_reg <= cor_cos;
            end
            OP_S_SD: sd_reg <= prod_reg[47:16];
            OP_A_START: div_neg_reg <= v_reg[31] ^ w_reg[31];
            OP_A_LAT: r_reg <= sat_quot(div_quo, div_neg_reg);
            OP_DONE: begin
                if (out_free) begin
                    ox_reg  <= x_reg;
                    oy_reg  <= y_reg;
                    ohd_reg <= h2_reg[23:8];
                    osl_reg <= lspd_reg;
                    osr_reg <= rspd_reg;
                    ola_reg <= lang_reg;
                    ora_reg <= rang_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign sts.div_busy = div_busy;
    assign sts.cor_busy = cor_busy;
    assign sts.arc      = arc_reg;
    assign sts.out_free = out_free;

    assign m_valid       = m_valid_reg;
    assign m_pos_x       = ox_reg;
    assign m_pos_y       = oy_reg;
    assign m_heading     = ohd_reg;
    assign m_speed_left  = osl_reg;
    assign m_speed_right = osr_reg;
    assign m_angle_left  = ola_reg;
    assign m_angle_right = ora_reg;
endmodule
`default_nettype wire

[rtl/core/ddro_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ddro_ctrl: sequencer of the drive ramp odometry unit
// Walks one item through ramp, odometry and pose steps.
// ----------------------------------------------------------------------------
module ddro_ctrl
    import ddro_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);
    typedef enum logic [26:0] {
        S_IDLE   = 27'd1 << 0,
        S_MSTEP  = 27'd1 << 1,
        S_RAMP   = 27'd1 << 2,
        S_MVL    = 27'd1 << 3,
        S_ANGL   = 27'd1 << 4,
        S_ANGR   = 27'd1 << 5,
        S_VSAT   = 27'd1 << 6,
        S_WSTART = 27'd1 << 7,
        S_WWAIT  = 27'd1 << 8,
        S_WLAT   = 27'd1 << 9,
        S_MWDT   = 27'd1 << 10,
        S_MTURN  = 27'd1 << 11,
        S_HEAD   = 27'd1 << 12,
        S_CWAIT  = 27'd1 << 13,
        S_SCLAT  = 27'd1 << 14,
        S_SMV    = 27'd1 << 15,
        S_SSD    = 27'd1 << 16,
        S_SMX    = 27'd1 << 17,
        S_SX     = 27'd1 << 18,
        S_SY     = 27'd1 << 19,
        S_ASTART = 27'd1 << 20,
        S_AWAIT  = 27'd1 << 21,
        S_ALAT   = 27'd1 << 22,
        S_AMX    = 27'd1 << 23,
        S_AX     = 27'd1 << 24,
        S_AY     = 27'd1 << 25,
        S_DONE   = 27'd1 << 26
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd.op        = OP_NOP;
        cmd.div_start = 1'b0;
        cmd.cor_start = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_MSTEP;
                end
            end
            S_MSTEP: begin cmd.op = OP_M_STEP; state_next = S_RAMP; end
            S_RAMP:  begin cmd.op = OP_RAMP;   state_next = S_MVL;  end
            S_MVL:   begin cmd.op = OP_M_VL;   state_next = S_ANGL; end
            S_ANGL:  begin cmd.op = OP_ANG_L;  state_next = S_ANGR; end
            S_ANGR:  begin cmd.op = OP_ANG_R;  state_next = S_VSAT; end
            S_VSAT:  begin cmd.op = OP_V;      state_next = S_WSTART; end
            S_WSTART: begin
                cmd.op        = OP_W_START;
                cmd.div_start = 1'b1;
                cmd.cor_start = 1'b1;
                state_next    = S_WWAIT;
            end
            S_WWAIT: begin
                if (!sts.div_busy) state_next = S_WLAT;
            end
            S_WLAT:  begin cmd.op = OP_W_LAT;  state_next = S_MWDT;  end
            S_MWDT:  begin cmd.op = OP_M_WDT;  state_next = S_MTURN; end
            S_MTURN: begin cmd.op = OP_M_TURN; state_next = S_HEAD;  end
            S_HEAD:  begin cmd.op = OP_HEAD;   state_next = S_CWAIT; end
            S_CWAIT: begin
                if (!sts.cor_busy) state_next = S_SCLAT;
            end
            S_SCLAT: begin
                cmd.op     = OP_SC_LAT;
                state_next = sts.arc ? S_ASTART : S_SMV;
            end
            S_SMV: begin cmd.op = OP_S_MV; state_next = S_SSD;  end
            S_SSD: begin cmd.op = OP_S_SD; state_next = S_SMX;  end
            S_SMX: begin cmd.op = OP_S_MX; state_next = S_SX;   end
            S_SX:  begin cmd.op = OP_S_X;  state_next = S_SY;   end
            S_SY:  begin cmd.op = OP_S_Y;  state_next = S_DONE; end
            S_ASTART: begin
                cmd.op        = OP_A_START;
                cmd.div_start = 1'b1;
                cmd.cor_start = 1'b1;
                state_next    = S_AWAIT;
            end
            S_AWAIT: begin
                if (!sts.div_busy && !sts.cor_busy) state_next = S_ALAT;
            end
            S_ALAT: begin cmd.op = OP_A_LAT; state_next = S_AMX;  end
            S_AMX:  begin cmd.op = OP_A_MX;  state_next = S_AX;   end
            S_AX:   begin cmd.op = OP_A_X;   state_next = S_AY;   end
            S_AY:   begin cmd.op = OP_A_Y;   state_next = S_DONE; end
            S_DONE: begin
                cmd.op = OP_DONE;
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

`ifndef SYNTH
    a_div_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WSTART) |=> sts.div_busy)
        else $error("divider not busy after start");
    a_arc_units_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ASTART) |=> (sts.div_busy && sts.cor_busy))
        else $error("arc step units not busy after start");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in work");
`endif
endmodule
`default_nettype wire

[rtl/core/diff_drive_ramp_odometry_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_ramp_odometry_unit: wheel speed ramp and differential odometry
// Per tick item: ramps both wheel speeds, integrates wheel angles and updates
// the robot pose; configuration over an APB-style register port.
// ----------------------------------------------------------------------------
// Each input item carries the left and right target wheel speeds of one tick
// and yields one result item with the new pose, heading and wheel state. The
// unit works on one item at a time. The radix-2 divider runs once for the
// angular speed and once more for the turn radius of an arc step, while the
// sine and cosine CORDIC overlaps each division. A result that is not taken
// holds the unit in its last step until the output register frees. A
// finished result waits in an output register, and the next item is accepted
// while it waits.
// Registers (byte address 4*i): 0 max_speed, 1 accel_step_rate, 2 time_step,
// 3 wheel_radius, 4 axle_length; write them only while the unit is idle.
// ----------------------------------------------------------------------------
module diff_drive_ramp_odometry_unit
    import ddro_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Configuration port.
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    // Input item channel.
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [22:0] s_target_left,
    input  wire logic signed [22:0] s_target_right,
    // Result item channel.
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_pos_x,
    output logic signed [31:0]      m_pos_y,
    output logic [15:0]             m_heading,
    output logic signed [22:0]      m_speed_left,
    output logic signed [22:0]      m_speed_right,
    output logic signed [31:0]      m_angle_left,
    output logic signed [31:0]      m_angle_right
);
    logic [21:0] max_speed_reg;
    logic [23:0] accel_reg;
    logic [15:0] time_step_reg;
    logic [19:0] wheel_radius_reg;
    logic [19:0] axle_length_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;
    cfg_t        cfg;
    cmd_t        cmd;
    sts_t        sts;

    // The port never inserts wait states; a write lands in its access cycle.
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg    <= RST_MAX_SPEED;
            accel_reg        <= RST_ACCEL;
            time_step_reg    <= RST_TIME_STEP;
            wheel_radius_reg <= RST_WHEEL_RAD;
            axle_length_reg  <= RST_AXLE_LEN;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAX_SPEED: max_speed_reg    <= pwdata[21:0];
                REG_ACCEL:     accel_reg        <= pwdata[23:0];
                REG_TIME_STEP: time_step_reg    <= pwdata[15:0];
                REG_WHEEL_RAD: wheel_radius_reg <= pwdata[19:0];
                REG_AXLE_LEN:  axle_length_reg  <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    // Reads return the register contents, zero above its width.
    always_comb begin
        case (reg_idx)
            REG_MAX_SPEED: prdata = {10'd0, max_speed_reg};
            REG_ACCEL:     prdata = {8'd0, accel_reg};
            REG_TIME_STEP: prdata = {16'd0, time_step_reg};
            REG_WHEEL_RAD: prdata = {12'd0, wheel_radius_reg};
            REG_AXLE_LEN:  prdata = {12'd0, axle_length_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.max_speed    = max_speed_reg;
    assign cfg.accel        = accel_reg;
    assign cfg.time_step    = time_step_reg;
    assign cfg.wheel_radius = wheel_radius_reg;
    assign cfg.axle_length  = axle_length_reg;

    // The sequencer steps the datapath through one item.
    ddro_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ddro_datapath #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .cmd            (cmd),
        .sts            (sts),
        .s_target_left  (s_target_left),
        .s_target_right (s_target_right),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_heading      (m_heading),
        .m_speed_left   (m_speed_left),
        .m_speed_right  (m_speed_right),
        .m_angle_left   (m_angle_left),
        .m_angle_right  (m_angle_right)
    );
endmodule
`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench of the drive ramp odometry unit
// Drives target wheel speed items into the unit and checks every result item
// against a cycle-free predictor of the ramp, odometry and pose arithmetic.
// Several register settings are visited, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
    import ddro_pkg::*;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic signed [22:0] speed_left;
        logic signed [22:0] speed_right;
        logic signed [31:0] angle_left;
        logic signed [31:0] angle_right;
    } pose_t;

    // Pose predictor and the queue of poses still to come out of the unit.
    class odometry_scoreboard;
        longint    max_speed, accel, time_step, wheel_radius, axle_length;
        longint    speed_l, speed_r;
        bit [31:0] pos_x, pos_y, angle_l, angle_r;
        bit [23:0] heading;
        pose_t     pending_poses[$];
        int        errors;
        longint    atan_tab[16] = '{536870912, 316933406, 167458907, 85004756,
            42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
            333772, 166886, 83443, 41722, 20861};

        function new();
            max_speed = RST_MAX_SPEED; accel = RST_ACCEL;
            time_step = RST_TIME_STEP; wheel_radius = RST_WHEEL_RAD;
            axle_length = RST_AXLE_LEN;
            speed_l = 0; speed_r = 0; pos_x = 0; pos_y = 0;
            angle_l = 0; angle_r = 0; heading = 0; errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, longint value);
            case (idx)
                REG_MAX_SPEED: max_speed    = value & 64'h3FFFFF;
                REG_ACCEL:     accel        = value & 64'hFFFFFF;
                REG_TIME_STEP: time_step    = value & 64'hFFFF;
                REG_WHEEL_RAD: wheel_radius = value & 64'hFFFFF;
                REG_AXLE_LEN:  axle_length  = value & 64'hFFFFF;
                default: ;
            endcase
        endfunction

        function longint clamp(longint v);
            if (v < -max_speed) return -max_speed;
            if (v > max_speed) return max_speed;
            return v;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint ramp(longint cur, longint tgt, longint stp);
            if (tgt > cur) begin
                cur += stp;
                if (cur > tgt) cur = tgt;
            end else if (tgt < cur) begin
                cur -= stp;
                if (cur < tgt) cur = tgt;
            end
            return cur;
        endfunction

        // Rotation-mode CORDIC on the heading widened to a 32-bit turn.
        function void sin_cos(bit [23:0] h, output longint s, output longint c);
            bit [31:0] p;
            bit        flip;
            longint    x, y, z, dx, dy;
            p = {h, 8'h00};
            flip = (p[31:30] == 2'd1) || (p[31:30] == 2'd2);
            if (flip) p += 32'h8000_0000;
            z = longint'($signed(p));
            x = CORDIC_GAIN_Q30;
            y = 0;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end else begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            c = x >>> 14;
            s = y >>> 14;
        endfunction

        function void note_targets(logic signed [22:0] tl_in, logic signed [22:0] tr_in);
            longint    tl, tr, stp, v, w, dturn, s1, c1, s2, c2, dx, dy, sd, r;
            bit [23:0] h2;
            pose_t     p;
            tl = clamp(longint'(tl_in));
            tr = clamp(longint'(tr_in));
            stp = (accel * time_step) >>> 16;
            speed_l = clamp(ramp(speed_l, tl, stp));
            speed_r = clamp(ramp(speed_r, tr, stp));
            angle_l += 32'((speed_l * time_step) >>> 16);
            angle_r += 32'((speed_r * time_step) >>> 16);
            v = sat32(((speed_r + speed_l) * wheel_radius) >>> 17);
            w = (axle_length == 0) ? 0
                : sat32(((speed_r - speed_l) * wheel_radius) / axle_length);
            dturn = (((w * time_step) >>> 16) * 64'sd683565276) >>> 24;
            h2 = heading + 24'(dturn);
            sin_cos(heading, s1, c1);
            // Below about 0.001 rad/s the arc radius blows up, so go straight.
            if (w > -66 && w < 66) begin
                sd = (v * time_step) >>> 16;
                dx = (sd * c1) >>> 16;
                dy = (sd * s1) >>> 16;
            end else begin
                sin_cos(h2, s2, c2);
                r = sat32((v * 65536) / w);
                dx = (r * (s2 - s1)) >>> 16;
                dy = -((r * (c2 - c1)) >>> 16);
            end
            pos_x += 32'(dx);
            pos_y += 32'(dy);
            heading = h2;
            p.pos_x = pos_x; p.pos_y = pos_y; p.heading = heading[23:8];
            p.speed_left = 23'(speed_l); p.speed_right = 23'(speed_r);
            p.angle_left = angle_l; p.angle_right = angle_r;
            pending_poses.push_back(p);
        endfunction

        function void check_pose(pose_t got);
            pose_t e;
            if (pending_poses.size() == 0) begin
                $error("result item with no expectation pending");
                errors++;
                return;
            end
            e = pending_poses.pop_front();
            if (got.pos_x !== e.pos_x) begin
                $error("pos_x expected %0d got %0d", e.pos_x, got.pos_x); errors++;
            end
            if (got.pos_y !== e.pos_y) begin
                $error("pos_y expected %0d got %0d", e.pos_y, got.pos_y); errors++;
            end
            if (got.heading !== e.heading) begin
                $error("heading expected %0d got %0d", e.heading, got.heading); errors++;
            end
            if (got.speed_left !== e.speed_left) begin
                $error("speed_left expected %0d got %0d", e.speed_left, got.speed_left);
                errors++;
            end
            if (got.speed_right !== e.speed_right) begin
                $error("speed_right expected %0d got %0d", e.speed_right, got.speed_right);
                errors++;
            end
            if (got.angle_left !== e.angle_left) begin
                $error("angle_left expected %0d got %0d", e.angle_left, got.angle_left);
                errors++;
            end
            if (got.angle_right !== e.angle_right) begin
                $error("angle_right expected %0d got %0d", e.angle_right, got.angle_right);
                errors++;
            end
        endfunction
    endclass

    localparam int IDLE_LIMIT = 20000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [22:0] s_target_left = '0, s_target_right = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_pos_x, m_pos_y, m_angle_left, m_angle_right;
    logic [15:0]        m_heading;
    logic signed [22:0] m_speed_left, m_speed_right;

    odometry_scoreboard pose_sb = new();
    // When cleared, neither side inserts idle cycles.
    bit                 idling_on = 1'b1;
    int                 quiet_cycles = 0;

    diff_drive_ramp_odometry_unit uut (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .s_valid, .s_ready, .s_target_left, .s_target_right,
        .m_valid, .m_ready, .m_pos_x, .m_pos_y, .m_heading, .m_speed_left,
        .m_speed_right, .m_angle_left, .m_angle_right
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // The receiver stalls with a probability of about 15 percent while idling is enabled.
    always @(negedge aclk) begin
        m_ready <= !(idling_on && ($urandom_range(99) < 15));
    end

    // Every accepted item, on either channel, restarts the watchdog count.
    always @(posedge aclk) begin
        pose_t got;
        if (s_valid && s_ready) begin
            pose_sb.note_targets(s_target_left, s_target_right);
        end
        if (m_valid && m_ready) begin
            got.pos_x = m_pos_x; got.pos_y = m_pos_y; got.heading = m_heading;
            got.speed_left = m_speed_left; got.speed_right = m_speed_right;
            got.angle_left = m_angle_left; got.angle_right = m_angle_right;
            pose_sb.check_pose(got);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("[diff_drive_ramp_odometry_unit] ERROR");
        $finish;
    end

    // One APB write: setup cycle, then access cycle; pready is always high.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pose_sb.set_reg(idx, value);
    endtask

    // Presents one item and returns at the falling edge after its acceptance,
    // with valid still high so that back-to-back items need no gap.
    task automatic send_targets(logic signed [22:0] tl, logic signed [22:0] tr);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(99) < 15) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_target_left <= tl;
        s_target_right <= tr;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Holds the sender back until every predicted pose has come out.
    task automatic drain();
        s_valid <= 1'b0;
        while (pose_sb.pending_poses.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic program_regs(int ms, int ac, int dt, int rad, int axle);
        drain();
        write_reg(REG_MAX_SPEED, ms);
        write_reg(REG_ACCEL, ac);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_WHEEL_RAD, rad);
        write_reg(REG_AXLE_LEN, axle);
    endtask

    // Random targets: full-range noise, nearly equal pairs for straight runs, and
    // pairs within the speed limit that produce ordinary arcs.
    task automatic random_targets(int count);
        logic signed [22:0] tl, tr;
        int lim;
        for (int n = 0; n < count; n++) begin
            lim = (pose_sb.max_speed > 0) ? int'(pose_sb.max_speed) : 1;
            case ($urandom_range(3))
                0, 1: begin
                    tl = 23'($urandom);
                    tr = 23'($urandom);
                end
                2: begin
                    tl = 23'($urandom_range(2 * lim) - lim);
                    tr = tl + 23'($urandom_range(8) - 4);
                end
                default: begin
                    tl = 23'($urandom_range(2 * lim) - lim);
                    tr = 23'($urandom_range(2 * lim) - lim);
                end
            endcase
            send_targets(tl, tr);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed items at the reset settings: field extremes, a slow ramp
        // toward the limit, straight runs and arcs in both directions.
        send_targets(23'sd0, 23'sd0);
        send_targets(23'sh3FFFFF, 23'sh3FFFFF);
        send_targets(-23'sh400000, -23'sh400000);
        send_targets(23'sh3FFFFF, -23'sh400000);
        send_targets(-23'sh400000, 23'sh3FFFFF);
        repeat (6) send_targets(23'sd411775, 23'sd411775);
        repeat (4) send_targets(23'sd411775, 23'sd200000);
        repeat (4) send_targets(-23'sd100000, 23'sd300000);
        send_targets(23'sd1, 23'sd0);
        send_targets(23'sd0, 23'sd0);
        random_targets(270);

        program_regs(4194303, 16777215, 65535, 1048575, 1048575);
        random_targets(190);
        // The limit drops below the present speeds; the ramp result is clamped.
        // A zero axle length forces straight steps.
        program_regs(200000, 50000, 3000, 20000, 0);
        random_targets(190);
        program_regs(0, 0, 1, 1, 1);
        random_targets(100);
        idling_on = 1'b0;
        program_regs(1000000, 2000000, 10000, 300000, 5000);
        random_targets(190);
        idling_on = 1'b1;
        program_regs(RST_MAX_SPEED, RST_ACCEL, RST_TIME_STEP, RST_WHEEL_RAD,
                     RST_AXLE_LEN);
        random_targets(190);

        s_valid <= 1'b0;
        while (pose_sb.pending_poses.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (pose_sb.errors == 0 && pose_sb.pending_poses.size() == 0) begin
            $display("[diff_drive_ramp_odometry_unit] OK");
        end else begin
            $display("[diff_drive_ramp_odometry_unit] ERROR");
        end
        $finish;
    end
endmodule
